// ----- rtl/core/wvst_pkg.sv -----
// Shared constants, widths and types of the window variance stagnation trigger.
`timescale 1ns / 1ps

package wvst_pkg;

  // Window geometry
  localparam int WIN_LEN    = 50;
  localparam int PTR_W      = $clog2(WIN_LEN);
  localparam int CNT_W      = $clog2(WIN_LEN + 1);

  // Field widths
  localparam int SAMPLE_W   = 16;
  localparam int SQ1_W      = 31;                  // square of one sample, at most 2^30
  localparam int SUM_W      = SAMPLE_W + CNT_W;    // signed running sum
  localparam int MAG_W      = SUM_W - 1;           // magnitude of the running sum
  localparam int SQ_W       = SQ1_W - 1 + CNT_W;   // running sum of squares
  localparam int PROD_W     = CNT_W + SQ_W;        // n * sumsq, also sum^2
  localparam int THR_W      = 32;
  localparam int CDLEN_W    = 8;
  localparam int DRIVE_W    = 17;
  localparam int VAR_W      = 30;
  localparam int CD_W       = 8;
  localparam int FRAC_W     = 16;

  // Configuration port
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] REG_THR   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CDLEN = 1'd1;
  localparam logic [THR_W-1:0]     THR_RST   = 32'd65536;
  localparam logic [CDLEN_W-1:0]   CDLEN_RST = 8'd100;

  // Fill-count thresholds for the variance and the trigger
  localparam int MIN_VAR_N  = 10;
  localparam int MIN_TRIG_N = 20;

  localparam logic [VAR_W-1:0]   VAR_MAX   = {VAR_W{1'b1}};
  localparam logic [DRIVE_W-1:0] DRIVE_ONE = 17'h10000;

  // Shared divider
  localparam int DIV_Q_W    = 31;
  localparam int DIV_DSR_W  = 32;
  localparam int DIV_DVD_W  = (PROD_W > THR_W + FRAC_W) ? PROD_W : THR_W + FRAC_W;
  localparam int DIV_CNT_W  = $clog2(DIV_Q_W + 1);

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] nbits;
  } div_req_t;

endpackage

// ----- rtl/core/wvst_in_if.sv -----
// Sample channel: valid, ready and one signed Q8.8 sample.
`timescale 1ns / 1ps

interface wvst_in_if;
  import wvst_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] vfe_sample;

  modport source (output valid, output vfe_sample, input ready);
  modport sink   (input valid, input vfe_sample, output ready);
endinterface

// ----- rtl/core/wvst_out_if.sv -----
// Result channel: valid, ready and the trigger result fields.
`timescale 1ns / 1ps

interface wvst_out_if;
  import wvst_pkg::*;

  logic               valid;
  logic               ready;
  logic               exploring;
  logic [DRIVE_W-1:0] drive;
  logic [VAR_W-1:0]   variance;
  logic [CD_W-1:0]    cooldown_left;

  modport source (output valid, output exploring, output drive, output variance,
                  output cooldown_left, input ready);
  modport sink   (input valid, input exploring, input drive, input variance,
                  input cooldown_left, output ready);
endinterface

// ----- rtl/core/wvst_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by variance and drive.
`timescale 1ns / 1ps

module wvst_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  wvst_pkg::div_req_t                 req,
  input  logic [wvst_pkg::DIV_DVD_W-1:0]     dividend,
  input  logic [wvst_pkg::DIV_DSR_W-1:0]     divisor,
  output logic                               done,
  output logic [wvst_pkg::DIV_Q_W-1:0]       quotient
);
  import wvst_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 done_r;
  logic [DIV_DSR_W-1:0] rem_r;
  logic [DIV_DSR_W-1:0] rem_nxt;
  logic [DIV_DSR_W-1:0] dsr_r;
  logic [DIV_Q_W-1:0]   dlo_r;
  logic [DIV_Q_W-1:0]   q_r;
  logic [DIV_CNT_W-1:0] bit_idx;
  logic [DIV_DSR_W:0]   rem_sh;
  logic                 q_bit;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    bit_idx = cnt_r - 1'b1;
    rem_sh  = {rem_r, dlo_r[bit_idx]};
    q_bit   = (rem_sh >= {1'b0, dsr_r});
    rem_nxt = q_bit ? DIV_DSR_W'(rem_sh - {1'b0, dsr_r}) : rem_sh[DIV_DSR_W-1:0];
  end

  // Load on start, then iterate until the bit count runs out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r <= req.nbits;
        rem_r <= DIV_DSR_W'(dividend >> req.nbits);
        dlo_r <= dividend[DIV_Q_W-1:0];
        dsr_r <= divisor;
        q_r   <= '0;
      end else if (cnt_r != '0) begin
        rem_r <= rem_nxt;
        q_r   <= {q_r[DIV_Q_W-2:0], q_bit};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ----- rtl/core/window_variance_stagnation_trigger.sv -----
// Top level: sample window in memory, running sums, variance and trigger sequencer.
`timescale 1ns / 1ps
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------------
//  in_ch   | sink      | valid / ready       | vfe_sample (s16, Q8.8)
//  out_ch  | source    | valid / ready       | exploring, drive, variance, cooldown_left
//  cfg_*   | write     | cfg_we              | cfg_index, cfg_wdata
//
//  One sample at a time: after the transfer a result passes S_READ, S_UPD, S_MUL, S_COOL
//  and S_OUT, with S_VDIV and S_VWAIT for the variance and S_DWAIT for the drive division.
//  Both divisions run on one restoring divider at one quotient bit per cycle.
//  Reset (rst_n low, synchronous) clears the sums, counters, state and configuration; the window
//  memory needs no clearing. A stalled result waits in the output register while the
//  next sample is taken; that sample is held back only at its final step.

module window_variance_stagnation_trigger (
  input  logic                              clk,
  input  logic                              rst_n,
  wvst_in_if.sink                           in_ch,
  wvst_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [wvst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wvst_pkg::CFG_W-1:0]        cfg_wdata
);
  import wvst_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_UPD,
    S_MUL,
    S_VDIV,
    S_VWAIT,
    S_COOL,
    S_DWAIT,
    S_OUT
  } state_t;

  state_t state_r;

  // Configuration
  logic [THR_W-1:0]   thr_r;
  logic [CDLEN_W-1:0] cdlen_r;

  // Window state
  logic [SAMPLE_W-1:0]        win_mem [WIN_LEN];
  logic signed [SAMPLE_W-1:0] rd_q_r;
  logic [PTR_W-1:0]           wp_r;
  logic [CNT_W-1:0]           fill_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic [SQ_W-1:0]            sumsq_r;
  logic [VAR_W-1:0]           held_var_r;
  logic [CD_W-1:0]            cd_r;

  // Per-sample working registers
  logic signed [SAMPLE_W-1:0] s_r;
  logic signed [SAMPLE_W-1:0] old_r;
  logic [SQ1_W-1:0]           sq_new_r;
  logic [SQ1_W-1:0]           sq_old_r;
  logic [PROD_W-1:0]          prod_a_r;
  logic [PROD_W-1:0]          prod_b_r;
  logic [2*CNT_W-1:0]         nn_r;
  logic                       expl_r;
  logic [DRIVE_W-1:0]         drive_r;

  // Output register
  logic                       out_valid_r;
  logic                       out_expl_r;
  logic [DRIVE_W-1:0]         out_drive_r;
  logic [VAR_W-1:0]           out_var_r;
  logic [CD_W-1:0]            out_cd_r;

  // Combinational helpers
  logic                       in_xfer;
  logic                       win_full;
  logic signed [31:0]         sq_new_w;
  logic signed [31:0]         sq_old_w;
  logic [MAG_W-1:0]           mag_w;
  logic [PROD_W-1:0]          mul_a_w;
  logic [PROD_W-1:0]          mul_b_w;
  logic [2*CNT_W-1:0]         mul_n_w;
  logic                       var_pos;
  logic                       trig;
  logic [THR_W-1:0]           thr_gap;
  div_req_t                   div_req;
  logic [DIV_DVD_W-1:0]       div_dvd;
  logic [DIV_DSR_W-1:0]       div_dsr;
  logic                       div_done;
  logic [DIV_Q_W-1:0]         div_q;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign win_full = (fill_r == CNT_W'(WIN_LEN));

  // Squares, sum magnitude and products
  always_comb begin
    sq_new_w = s_r * s_r;
    sq_old_w = rd_q_r * rd_q_r;
    mag_w    = (sum_r < 0) ? MAG_W'(-sum_r) : MAG_W'(sum_r);
    mul_a_w  = fill_r * sumsq_r;
    mul_b_w  = mag_w * mag_w;
    mul_n_w  = fill_r * fill_r;
    var_pos  = (prod_a_r > prod_b_r);
    thr_gap  = thr_r - THR_W'(held_var_r);
    trig     = (THR_W'(held_var_r) < thr_r) && (fill_r >= CNT_W'(MIN_TRIG_N));
  end

  // Divider requests: variance in S_VDIV, drive in S_COOL
  always_comb begin
    div_req.start = 1'b0;
    div_req.nbits = DIV_CNT_W'(DIV_Q_W);
    div_dvd       = DIV_DVD_W'({thr_gap, {FRAC_W{1'b0}}});
    div_dsr       = thr_r;
    case (state_r)
      S_VDIV: begin
        div_req.start = var_pos;
        div_dvd       = DIV_DVD_W'(prod_a_r - prod_b_r);
        div_dsr       = DIV_DSR_W'(nn_r);
      end
      S_COOL: begin
        div_req.start = (cd_r == '0) && trig;
        div_req.nbits = DIV_CNT_W'(DRIVE_W);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  wvst_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  // Window memory: read on transfer, write in the next cycle (S_READ) at the same pointer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rd_q_r <= signed'(win_mem[wp_r]);
    end
    if (state_r == S_READ) begin
      win_mem[wp_r] <= s_r;
    end
  end

  // Sequencer, state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thr_r       <= THR_RST;
      cdlen_r     <= CDLEN_RST;
      wp_r        <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      sumsq_r     <= '0;
      held_var_r  <= '0;
      cd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Configuration writes
      if (cfg_we) begin
        case (cfg_index)
          REG_THR:   thr_r   <= cfg_wdata[THR_W-1:0];
          REG_CDLEN: cdlen_r <= cfg_wdata[CDLEN_W-1:0];
          default:   thr_r   <= thr_r;
        endcase
      end

      // Drop the result once transferred
      if (out_ch.ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            s_r     <= in_ch.vfe_sample;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          sq_new_r <= sq_new_w[SQ1_W-1:0];
          sq_old_r <= win_full ? sq_old_w[SQ1_W-1:0] : '0;
          old_r    <= win_full ? rd_q_r : '0;
          state_r  <= S_UPD;
        end
        S_UPD: begin
          sum_r   <= sum_r - SUM_W'(old_r) + SUM_W'(s_r);
          sumsq_r <= sumsq_r - SQ_W'(sq_old_r) + SQ_W'(sq_new_r);
          if (!win_full) begin
            fill_r <= fill_r + 1'b1;
          end
          wp_r    <= (wp_r == PTR_W'(WIN_LEN - 1)) ? '0 : wp_r + 1'b1;
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_a_r <= mul_a_w;
          prod_b_r <= mul_b_w;
          nn_r     <= mul_n_w;
          state_r  <= (fill_r >= CNT_W'(MIN_VAR_N)) ? S_VDIV : S_COOL;
        end
        S_VDIV: begin
          if (var_pos) begin
            state_r <= S_VWAIT;
          end else begin
            held_var_r <= '0;
            state_r    <= S_COOL;
          end
        end
        S_VWAIT: begin
          if (div_done) begin
            held_var_r <= (div_q > DIV_Q_W'(VAR_MAX)) ? VAR_MAX : div_q[VAR_W-1:0];
            state_r    <= S_COOL;
          end
        end
        S_COOL: begin
          expl_r  <= 1'b0;
          drive_r <= '0;
          if (cd_r != '0) begin
            cd_r    <= cd_r - 1'b1;
            state_r <= S_OUT;
          end else if (trig) begin
            state_r <= S_DWAIT;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_DWAIT: begin
          if (div_done) begin
            expl_r  <= 1'b1;
            drive_r <= (div_q > DIV_Q_W'(DRIVE_ONE)) ? DRIVE_ONE : div_q[DRIVE_W-1:0];
            cd_r    <= CD_W'(cdlen_r);
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          // Hold until the output register is free
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_expl_r  <= expl_r;
            out_drive_r <= drive_r;
            out_var_r   <= held_var_r;
            out_cd_r    <= cd_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.exploring     = out_expl_r;
  assign out_ch.drive         = out_drive_r;
  assign out_ch.variance      = out_var_r;
  assign out_ch.cooldown_left = out_cd_r;

endmodule

// ----- rtl/core/wvst_chk.sv -----
// Port checker for the window variance stagnation trigger, bound to the top level.
`timescale 1ns / 1ps

module wvst_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         exploring,
  input logic [wvst_pkg::DRIVE_W-1:0] drive,
  input logic [wvst_pkg::VAR_W-1:0]   variance,
  input logic [wvst_pkg::CD_W-1:0]    cooldown_left
);
  import wvst_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(exploring) && $stable(drive) &&
                                $stable(variance) && $stable(cooldown_left))
    else $error("stalled result changed");

  // Drive only with exploration, never above one
  a_drive_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !exploring |-> drive == '0)
    else $error("drive without exploration");

  a_drive_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> drive <= DRIVE_ONE)
    else $error("drive above one");

  // One sample at a time: busy right after a transfer
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second sample taken while busy");

endmodule

bind window_variance_stagnation_trigger wvst_chk u_wvst_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .exploring     (out_ch.exploring),
  .drive         (out_ch.drive),
  .variance      (out_ch.variance),
  .cooldown_left (out_ch.cooldown_left)
);
